### hw/rtl/tsyn_pkg.sv
// ----------------------------------------------------------------------------
// tsyn_pkg
// Shared types and constants for the TCP SYN header builder: register
// indexes, fixed header fields and the header word count.
// ----------------------------------------------------------------------------
package tsyn_pkg;

    typedef logic [31:0] t_word;
    typedef logic [15:0] t_half;

    localparam int HDR_WORDS = 10;
    localparam int POS_W     = 4;

    localparam logic [7:0] CFG_WINDOW_SIZE   = 8'd0;
    localparam logic [7:0] CFG_TIME_TO_LIVE  = 8'd1;
    localparam logic [7:0] CFG_DONT_FRAGMENT = 8'd2;
    localparam logic [7:0] CFG_PRIV_CHECK_EN = 8'd3;

    localparam logic [15:0] RST_WINDOW_SIZE = 16'd8192;
    localparam logic [7:0]  RST_TTL         = 8'd2;

    localparam t_word IP_WORD0     = 32'h4500_0028;
    localparam t_half IP_VER_LEN   = 16'h4500;
    localparam t_half IP_TOT_LEN   = 16'h0028;
    localparam t_half IP_DF_FLAG   = 16'h4000;
    localparam logic [7:0] IP_PROTO_TCP = 8'h06;
    localparam t_half TCP_SEG_LEN  = 16'h0014;
    localparam t_half TCP_OFF_FLAG = 16'h5002;

    localparam logic [7:0] OCT_LOOPBACK = 8'd127;
    localparam logic [7:0] OCT_TEN      = 8'd10;
    localparam logic [7:0] OCT_172      = 8'd172;
    localparam logic [7:0] OCT_192      = 8'd192;
    localparam logic [7:0] OCT_168      = 8'd168;
    localparam logic [7:0] OCT_16       = 8'd16;
    localparam logic [7:0] OCT_31       = 8'd31;

    localparam logic [3:0] POS_LAST = 4'd9;

endpackage

### hw/rtl/tcp_syn_header_builder_unit.sv
// ----------------------------------------------------------------------------
// tcp_syn_header_builder_unit
// Builds a 40-byte IPv4 plus TCP SYN header with both checksums from one
// connection request and streams it out as ten 32-bit words.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall  addresses, ports, seq, ack
//   out      output     o_out_valid / i_out_stall header word, position, flags
//   cfg      input      i_cfg_we                 index, data
//
// three checksum stages (partial sums, fold, finish) feed a ten-word shift
// line; the first word becomes valid once a request has passed through the
// stages into the shift line
// the shift line sends one word per cycle unless stalled, ten words per
// request (one word if rejected); the next request waits in the stages
// reset is synchronous, clears all valid bits and loads the config defaults
// a stalled output word holds; requests back up through the stages
// ----------------------------------------------------------------------------
module tcp_syn_header_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port_number,
    input  logic [15:0] i_dest_port_number,
    input  logic [31:0] i_sequence_number,
    input  logic [31:0] i_ack_number,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_header_word,
    output logic [3:0]  o_word_position,
    output logic        o_last_word,
    output logic        o_rejected,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // config registers
    logic [15:0] r_window_size;
    logic [7:0]  r_ttl;
    logic        r_df;
    logic        r_priv_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= tsyn_pkg::RST_WINDOW_SIZE;
            r_ttl         <= tsyn_pkg::RST_TTL;
            r_df          <= 1'b0;
            r_priv_en     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsyn_pkg::CFG_WINDOW_SIZE:   r_window_size <= i_cfg_data;
                tsyn_pkg::CFG_TIME_TO_LIVE:  r_ttl         <= i_cfg_data[7:0];
                tsyn_pkg::CFG_DONT_FRAGMENT: r_df          <= i_cfg_data[0];
                tsyn_pkg::CFG_PRIV_CHECK_EN: r_priv_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage enables
    logic en1, en2, en3, load;
    logic r1_valid, r2_valid, r3_valid;

    logic        r_busy;
    logic        r_rej;
    logic [3:0]  r_pos;
    tsyn_pkg::t_word r_shift [tsyn_pkg::HDR_WORDS];

    logic out_take;
    assign out_take = r_busy && !i_out_stall;
    assign load     = !r_busy || (out_take && o_last_word);
    assign en3      = !r3_valid || load;
    assign en2      = !r2_valid || en3;
    assign en1      = !r1_valid || en2;
    assign o_in_stall = !en1;

    // stage 1: partial sums and private check
    logic [7:0] oct0, oct1;
    logic       is_private;
    logic [17:0] n1_addr_sum;
    logic [18:0] n1_tcp_sum;

    assign oct0 = i_dest_address[31:24];
    assign oct1 = i_dest_address[23:16];
    assign is_private = (oct0 == tsyn_pkg::OCT_LOOPBACK) || (oct0 == tsyn_pkg::OCT_TEN) ||
                        ((oct0 == tsyn_pkg::OCT_172) && (oct1 >= tsyn_pkg::OCT_16) &&
                         (oct1 <= tsyn_pkg::OCT_31)) ||
                        ((oct0 == tsyn_pkg::OCT_192) && (oct1 == tsyn_pkg::OCT_168));

    assign n1_addr_sum = 18'(i_source_address[31:16]) + 18'(i_source_address[15:0])
                       + 18'(i_dest_address[31:16]) + 18'(i_dest_address[15:0]);
    assign n1_tcp_sum  = 19'(i_source_port_number) + 19'(i_dest_port_number)
                       + 19'(i_sequence_number[31:16]) + 19'(i_sequence_number[15:0])
                       + 19'(i_ack_number[31:16]) + 19'(i_ack_number[15:0]);

    logic        r1_rej;
    logic [31:0] r1_src, r1_dst, r1_seq, r1_ack;
    logic [15:0] r1_sport, r1_dport;
    logic [17:0] r1_addr_sum;
    logic [18:0] r1_tcp_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_rej      <= r_priv_en && !is_private;
            r1_src      <= i_source_address;
            r1_dst      <= i_dest_address;
            r1_sport    <= i_source_port_number;
            r1_dport    <= i_dest_port_number;
            r1_seq      <= i_sequence_number;
            r1_ack      <= i_ack_number;
            r1_addr_sum <= n1_addr_sum;
            r1_tcp_sum  <= n1_tcp_sum;
        end
    end

    // stage 2: add fixed fields, first fold
    logic [19:0] ip_raw, tcp_raw;
    logic [16:0] n2_ip_fold, n2_tcp_fold;

    assign ip_raw  = 20'(r1_addr_sum) + 20'(tsyn_pkg::IP_VER_LEN) + 20'(tsyn_pkg::IP_TOT_LEN)
                   + (r_df ? 20'(tsyn_pkg::IP_DF_FLAG) : 20'd0)
                   + 20'({r_ttl, tsyn_pkg::IP_PROTO_TCP});
    assign tcp_raw = 20'(r1_addr_sum) + 20'(r1_tcp_sum) + 20'(tsyn_pkg::IP_PROTO_TCP)
                   + 20'(tsyn_pkg::TCP_SEG_LEN) + 20'(tsyn_pkg::TCP_OFF_FLAG)
                   + 20'(r_window_size);
    assign n2_ip_fold  = 17'(ip_raw[15:0]) + 17'(ip_raw[19:16]);
    assign n2_tcp_fold = 17'(tcp_raw[15:0]) + 17'(tcp_raw[19:16]);

    logic        r2_rej;
    logic [31:0] r2_src, r2_dst, r2_seq, r2_ack;
    logic [15:0] r2_sport, r2_dport;
    logic [16:0] r2_ip_fold, r2_tcp_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_rej      <= r1_rej;
            r2_src      <= r1_src;
            r2_dst      <= r1_dst;
            r2_sport    <= r1_sport;
            r2_dport    <= r1_dport;
            r2_seq      <= r1_seq;
            r2_ack      <= r1_ack;
            r2_ip_fold  <= n2_ip_fold;
            r2_tcp_fold <= n2_tcp_fold;
        end
    end

    // stage 3: final fold and complement
    logic [15:0] n3_ip_ck, n3_tcp_ck;
    assign n3_ip_ck  = ~(r2_ip_fold[15:0] + 16'(r2_ip_fold[16]));
    assign n3_tcp_ck = ~(r2_tcp_fold[15:0] + 16'(r2_tcp_fold[16]));

    logic        r3_rej;
    logic [31:0] r3_src, r3_dst, r3_seq, r3_ack;
    logic [15:0] r3_sport, r3_dport;
    logic [15:0] r3_ip_ck, r3_tcp_ck;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_rej    <= r2_rej;
            r3_src    <= r2_src;
            r3_dst    <= r2_dst;
            r3_sport  <= r2_sport;
            r3_dport  <= r2_dport;
            r3_seq    <= r2_seq;
            r3_ack    <= r2_ack;
            r3_ip_ck  <= n3_ip_ck;
            r3_tcp_ck <= n3_tcp_ck;
        end
    end

    // output shift line
    tsyn_pkg::t_word n_words [tsyn_pkg::HDR_WORDS];

    always_comb begin
        n_words[0] = r3_rej ? 32'd0 : tsyn_pkg::IP_WORD0;
        n_words[1] = r_df ? {16'd0, tsyn_pkg::IP_DF_FLAG} : 32'd0;
        n_words[2] = {r_ttl, tsyn_pkg::IP_PROTO_TCP, r3_ip_ck};
        n_words[3] = r3_src;
        n_words[4] = r3_dst;
        n_words[5] = {r3_sport, r3_dport};
        n_words[6] = r3_seq;
        n_words[7] = r3_ack;
        n_words[8] = {tsyn_pkg::TCP_OFF_FLAG, r_window_size};
        n_words[9] = {r3_tcp_ck, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_rej  <= 1'b0;
        end else if (load) begin
            r_busy <= r3_valid;
            r_pos  <= '0;
            r_rej  <= r3_rej;
        end else if (out_take) begin
            r_pos  <= r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < tsyn_pkg::HDR_WORDS; k++) begin
                r_shift[k] <= n_words[k];
            end
        end else if (out_take) begin
            for (int k = 0; k < tsyn_pkg::HDR_WORDS - 1; k++) begin
                r_shift[k] <= r_shift[k + 1];
            end
        end
    end

    assign o_out_valid     = r_busy;
    assign o_header_word   = r_shift[0];
    assign o_word_position = r_pos;
    assign o_last_word     = r_rej || (r_pos == tsyn_pkg::POS_LAST);
    assign o_rejected      = r_rej;

endmodule

### hw/rtl/tsyn_checker.sv
// ----------------------------------------------------------------------------
// tsyn_checker
// Port-level checks on the header word stream of the SYN header builder.
// ----------------------------------------------------------------------------
module tsyn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_header_word,
    input logic [3:0]  o_word_position,
    input logic        o_last_word,
    input logic        o_rejected
);

    // reject is a single zero word
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |->
            o_last_word && (o_word_position == 4'd0) && (o_header_word == 32'd0))
        else $error("rejected request not a single zero word");

    // word ten closes the header
    a_last_at_nine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_word_position == tsyn_pkg::POS_LAST) |-> o_last_word)
        else $error("position nine without last word");

    // words of one request come in order with no gap
    a_position_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=>
            o_out_valid && (o_word_position == $past(o_word_position) + 4'd1))
        else $error("header word sequence broken");

    // a new request starts at word zero
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_word ##1 o_out_valid |->
            o_word_position == 4'd0)
        else $error("request did not start at word zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_header_word) && $stable(o_word_position))
        else $error("stalled output changed");

endmodule

bind tcp_syn_header_builder_unit tsyn_checker u_tsyn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_header_word   (o_header_word),
    .o_word_position (o_word_position),
    .o_last_word     (o_last_word),
    .o_rejected      (o_rejected)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TCP SYN header builder. Connection requests
// go in through the valid/stall input channel; each one is predicted on
// acceptance into ten IPv4/TCP header words with both checksums, or into a
// single rejection word when the private address check fails. Every output
// word is compared against the oldest prediction. Directed tests cover the
// address ranges, field extremes and register extremes; random traffic then
// runs under several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          END_WAIT_CYCLES = 20;
    localparam int          MAX_REPORTS     = 10;
    localparam int          IDLE_PCT        = 9;
    localparam logic [7:0]  CFG_INDEX_SPARE = 8'd4;
    localparam logic [7:0]  CFG_INDEX_TOP   = 8'hff;

    typedef struct packed {
        tsyn_pkg::t_word src;
        tsyn_pkg::t_word dst;
        tsyn_pkg::t_half sport;
        tsyn_pkg::t_half dport;
        tsyn_pkg::t_word seq;
        tsyn_pkg::t_word ack;
    } t_conn_req;

    typedef struct packed {
        tsyn_pkg::t_word word;
        logic [3:0]      pos;
        logic            last;
        logic            rej;
    } t_hdr_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_source_address;
    logic [31:0] i_dest_address;
    logic [15:0] i_source_port_number;
    logic [15:0] i_dest_port_number;
    logic [31:0] i_sequence_number;
    logic [31:0] i_ack_number;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_header_word;
    logic [3:0]  o_word_position;
    logic        o_last_word;
    logic        o_rejected;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // shadow copy of the block's registers
    logic [15:0] cfg_window;
    logic [7:0]  cfg_ttl;
    logic        cfg_df;
    logic        cfg_check;

    t_hdr_result pending_words[$];
    int          mismatch_count;
    int          in_idle_pct;
    int          out_idle_pct;
    int          stalled_cycles;

    tcp_syn_header_builder_unit u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_source_address     (i_source_address),
        .i_dest_address       (i_dest_address),
        .i_source_port_number (i_source_port_number),
        .i_dest_port_number   (i_dest_port_number),
        .i_sequence_number    (i_sequence_number),
        .i_ack_number         (i_ack_number),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_header_word        (o_header_word),
        .o_word_position      (o_word_position),
        .o_last_word          (o_last_word),
        .o_rejected           (o_rejected),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic is_private_dest(input tsyn_pkg::t_word a);
        return a[31:24] == tsyn_pkg::OCT_LOOPBACK || a[31:24] == tsyn_pkg::OCT_TEN ||
               (a[31:24] == tsyn_pkg::OCT_172 && a[23:16] >= tsyn_pkg::OCT_16 &&
                a[23:16] <= tsyn_pkg::OCT_31) ||
               (a[31:24] == tsyn_pkg::OCT_192 && a[23:16] == tsyn_pkg::OCT_168);
    endfunction

    // ones' complement add of both halves with end-around carry
    function automatic logic [31:0] csum_add(input logic [31:0] acc,
                                             input tsyn_pkg::t_word w);
        logic [31:0] s;
        s = acc + {16'h0, w[31:16]} + {16'h0, w[15:0]};
        while (s[31:16] != 16'h0)
            s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return s;
    endfunction

    function automatic void build_expected_header(input t_conn_req r);
        tsyn_pkg::t_word hdr [tsyn_pkg::HDR_WORDS];
        logic [31:0]     acc;
        t_hdr_result     res;
        if (cfg_check && !is_private_dest(r.dst)) begin
            res.word = '0;
            res.pos  = '0;
            res.last = 1'b1;
            res.rej  = 1'b1;
            pending_words.push_back(res);
            return;
        end
        hdr[0] = tsyn_pkg::IP_WORD0;
        hdr[1] = {16'h0, cfg_df ? tsyn_pkg::IP_DF_FLAG : 16'h0};
        hdr[2] = {cfg_ttl, tsyn_pkg::IP_PROTO_TCP, 16'h0};
        hdr[3] = r.src;
        hdr[4] = r.dst;
        acc = '0;
        for (int i = 0; i < 5; i++)
            acc = csum_add(acc, hdr[i]);
        hdr[2][15:0] = ~acc[15:0];
        hdr[5] = {r.sport, r.dport};
        hdr[6] = r.seq;
        hdr[7] = r.ack;
        hdr[8] = {tsyn_pkg::TCP_OFF_FLAG, cfg_window};
        hdr[9] = '0;
        // pseudo-header then tcp header
        acc = '0;
        acc = csum_add(acc, r.src);
        acc = csum_add(acc, r.dst);
        acc = csum_add(acc, {8'h0, tsyn_pkg::IP_PROTO_TCP, tsyn_pkg::TCP_SEG_LEN});
        for (int i = 5; i < tsyn_pkg::HDR_WORDS; i++)
            acc = csum_add(acc, hdr[i]);
        hdr[9] = {~acc[15:0], 16'h0};
        for (int i = 0; i < tsyn_pkg::HDR_WORDS; i++) begin
            res.word = hdr[i];
            res.pos  = i[3:0];
            res.last = (i[3:0] == tsyn_pkg::POS_LAST);
            res.rej  = 1'b0;
            pending_words.push_back(res);
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic cfg_write(input logic [7:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            tsyn_pkg::CFG_WINDOW_SIZE:   cfg_window = data;
            tsyn_pkg::CFG_TIME_TO_LIVE:  cfg_ttl    = data[7:0];
            tsyn_pkg::CFG_DONT_FRAGMENT: cfg_df     = data[0];
            tsyn_pkg::CFG_PRIV_CHECK_EN: cfg_check  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic cfg_write_all(input logic [15:0] window, input logic [15:0] ttl,
                                 input logic [15:0] df, input logic [15:0] check);
        cfg_write(tsyn_pkg::CFG_WINDOW_SIZE, window);
        cfg_write(tsyn_pkg::CFG_TIME_TO_LIVE, ttl);
        cfg_write(tsyn_pkg::CFG_DONT_FRAGMENT, df);
        cfg_write(tsyn_pkg::CFG_PRIV_CHECK_EN, check);
    endtask

    // called at a falling edge; valid stays high on return
    task automatic send_request(input t_conn_req r);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_source_address     <= r.src;
        i_dest_address       <= r.dst;
        i_source_port_number <= r.sport;
        i_dest_port_number   <= r.dport;
        i_sequence_number    <= r.seq;
        i_ack_number         <= r.ack;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        build_expected_header(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic t_conn_req make_req(input tsyn_pkg::t_word src,
                                           input tsyn_pkg::t_word dst,
                                           input tsyn_pkg::t_half sport,
                                           input tsyn_pkg::t_half dport,
                                           input tsyn_pkg::t_word seq,
                                           input tsyn_pkg::t_word ack);
        t_conn_req r;
        r.src   = src;
        r.dst   = dst;
        r.sport = sport;
        r.dport = dport;
        r.seq   = seq;
        r.ack   = ack;
        return r;
    endfunction

    function automatic tsyn_pkg::t_word pick_dest();
        tsyn_pkg::t_word a;
        a = $urandom();
        case ($urandom_range(9))
            0: a[31:24] = tsyn_pkg::OCT_LOOPBACK;
            1: a[31:24] = tsyn_pkg::OCT_TEN;
            2, 3: begin
                a[31:24] = tsyn_pkg::OCT_172;
                a[23:16] = 8'($urandom_range(16, 31));
            end
            4, 5, 6: begin
                a[31:24] = tsyn_pkg::OCT_192;
                a[23:16] = tsyn_pkg::OCT_168;
            end
            7: begin
                // just outside the 172.16/12 block
                a[31:24] = tsyn_pkg::OCT_172;
                a[23:16] = $urandom_range(1) ? 8'd15 : 8'd32;
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_conn_req random_req();
        tsyn_pkg::t_word ack;
        ack = ($urandom_range(4) == 0) ? 32'h0 : $urandom();
        return make_req($urandom(), pick_dest(), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), $urandom(), ack);
    endfunction

    task automatic test_address_ranges();
        tsyn_pkg::t_word dests[15];
        dests = '{32'h7f00_0001, 32'h0a01_0203, 32'hac10_0000, 32'hac1f_ffff,
                  32'hc0a8_0101, 32'hac0f_ffff, 32'hac20_0000, 32'hc0a7_0101,
                  32'hc0a9_0101, 32'h0b00_0001, 32'h0900_0001, 32'h7e00_0001,
                  32'h8000_0001, 32'h0000_0000, 32'hffff_ffff};
        foreach (dests[i])
            send_request(make_req($urandom(), dests[i], 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)), $urandom(), 32'h0));
    endtask

    task automatic test_field_extremes();
        wait_drained();
        // values wider than the register keep only the low bits
        cfg_write_all(16'hffff, 16'ha5ff, 16'hffff, 16'hfffe);
        cfg_write(CFG_INDEX_SPARE, 16'h1234);
        send_request(make_req('0, '0, '0, '0, '0, '0));
        send_request(make_req('1, '1, '1, '1, '1, '1));
        send_request(make_req(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 16'h5555,
                              32'haaaa_aaaa, 32'h5555_5555));
        send_request(make_req(32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa,
                              32'h5555_5555, 32'haaaa_aaaa));
        send_request(make_req(32'hffff_0000, 32'h0000_ffff, 16'hff00, 16'h00ff,
                              32'h0000_ffff, 32'hffff_0000));
        send_request(make_req(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001,
                              32'h8000_0000, 32'h0000_0001));
    endtask

    task automatic test_register_extremes();
        wait_drained();
        cfg_write_all(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        cfg_write(CFG_INDEX_TOP, 16'hffff);
        repeat (4)
            send_request(random_req());
    endtask

    task automatic test_back_to_back();
        wait_drained();
        cfg_write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'h0001, 16'h0001);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (40)
            send_request(random_req());
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_traffic();
        logic check_on;
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            check_on = (phase != 2);
            cfg_write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)),
                          {15'($urandom_range(0, 32767)), check_on});
            for (int n = 0; n < 50; n++) begin
                if (phase == 1 && n == 25)
                    wait_drained();
                send_request(random_req());
            end
        end
    endtask

    // output side stall
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_hdr_result got;
        t_hdr_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.word = o_header_word;
            got.pos  = o_word_position;
            got.last = o_last_word;
            got.rej  = o_rejected;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word %h pos %0d last %b rej %b",
                             got.word, got.pos, got.last, got.rej);
            end else begin
                want = pending_words.pop_front();
                if (got.word !== want.word || got.pos !== want.pos ||
                    got.last !== want.last || got.rej !== want.rej) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.word, want.pos, want.last, want.rej,
                                 got.word, got.pos, got.last, got.rej);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_source_address     = '0;
        i_dest_address       = '0;
        i_source_port_number = '0;
        i_dest_port_number   = '0;
        i_sequence_number    = '0;
        i_ack_number         = '0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = '0;
        i_cfg_data           = '0;
        cfg_window           = tsyn_pkg::RST_WINDOW_SIZE;
        cfg_ttl              = tsyn_pkg::RST_TTL;
        cfg_df               = 1'b0;
        cfg_check            = 1'b1;
        mismatch_count       = 0;
        stalled_cycles       = 0;
        in_idle_pct          = IDLE_PCT;
        out_idle_pct         = IDLE_PCT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_address_ranges();
        test_field_extremes();
        test_register_extremes();
        test_back_to_back();
        test_random_traffic();

        wait_drained();
        repeat (END_WAIT_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
